[hw/rtl/les_pkg.sv]
`timescale 1ns / 1ps

package les_pkg;

   localparam int CHAR_W     = 8;
   localparam int SIZE_W     = 11;
   localparam int POS_W      = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH    = 1'b0,
      CSR_OBSTACLE_CHAR = 1'b1
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] GRID_WIDTH_RESET    = 11'd1;
   localparam logic [CHAR_W-1:0]     OBSTACLE_CHAR_RESET = 8'd111;

   // cell leaving the compute stage this cycle
   typedef struct packed {
      logic step;
      logic last;
   } les_ctl_type;

endpackage

[hw/rtl/les_ram.sv]
`timescale 1ns / 1ps

module les_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/les_best.sv]
`timescale 1ns / 1ps

module les_best #(
   parameter int RUN_W = 11,
   parameter int ROW_W = 10,
   parameter int COL_W = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  les_pkg::les_ctl_type        ctl,
   input  logic [RUN_W-1:0]            run,
   input  logic [ROW_W-1:0]            row,
   input  logic [COL_W-1:0]            col,
   output logic                        take_ok,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_found,
   output logic [les_pkg::SIZE_W-1:0]  rsp_square_size,
   output logic [les_pkg::POS_W-1:0]   rsp_top_row,
   output logic [les_pkg::POS_W-1:0]   rsp_left_col
);

   import les_pkg::*;

   localparam int CMP_W = (RUN_W > ROW_W) ? RUN_W : ROW_W;

   logic [RUN_W-1:0] best_size_ff, best_size_in;
   logic [ROW_W-1:0] best_top_ff, best_top_in;
   logic [COL_W-1:0] best_left_ff, best_left_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_found_ff;
   logic [SIZE_W-1:0] rsp_size_ff;
   logic [POS_W-1:0]  rsp_top_ff, rsp_left_ff;

   logic             newer;
   logic [RUN_W-1:0] run_m1;
   logic [CMP_W-1:0] row_x, col_x, run_m1_x;
   logic [ROW_W-1:0] cand_top;
   logic [COL_W-1:0] cand_left;
   logic [RUN_W-1:0] size_nx;
   logic [ROW_W-1:0] top_nx;
   logic [COL_W-1:0] left_nx;
   logic [31:0]      size_wide, top_wide, left_wide;

   always_comb begin
      // strictly larger only: keeps the earliest top-left corner on ties
      newer    = ctl.step && (run > best_size_ff);
      run_m1   = run - RUN_W'(1);
      row_x    = CMP_W'(row);
      col_x    = CMP_W'(col);
      run_m1_x = CMP_W'(run_m1);
      cand_top  = (row_x >= run_m1_x) ? ROW_W'(row_x - run_m1_x) : '0;
      cand_left = (col_x >= run_m1_x) ? COL_W'(col_x - run_m1_x) : '0;
      size_nx  = newer ? run : best_size_ff;
      top_nx   = newer ? cand_top : best_top_ff;
      left_nx  = newer ? cand_left : best_left_ff;
      size_wide = 32'(size_nx);
      top_wide  = 32'(top_nx);
      left_wide = 32'(left_nx);
   end

   always_comb begin
      best_size_in = best_size_ff;
      best_top_in  = best_top_ff;
      best_left_in = best_left_ff;
      if (ctl.step) begin
         if (ctl.last) begin
            best_size_in = '0;
            best_top_in  = '0;
            best_left_in = '0;
         end else begin
            best_size_in = size_nx;
            best_top_in  = top_nx;
            best_left_in = left_nx;
         end
      end
   end

   assign take_ok = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (ctl.step && ctl.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_size_ff <= '0;
         best_top_ff  <= '0;
         best_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         best_size_ff <= best_size_in;
         best_top_ff  <= best_top_in;
         best_left_ff <= best_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // top/left stay zero while size is zero, so no extra masking for found = 0
   always_ff @(posedge clock) begin
      if (ctl.step && ctl.last) begin
         rsp_found_ff <= (size_nx != '0);
         rsp_size_ff  <= size_wide[SIZE_W-1:0];
         rsp_top_ff   <= top_wide[POS_W-1:0];
         rsp_left_ff  <= left_wide[POS_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_square_size = rsp_size_ff;
   assign rsp_top_row     = rsp_top_ff;
   assign rsp_left_col    = rsp_left_ff;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.step && ctl.last))
      else $error("result beat without a last cell");

   a_last_needs_room: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && ctl.last) |-> take_ok)
      else $error("last cell retired over a held result");

   a_best_clears: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && ctl.last) |=> (best_size_ff == '0))
      else $error("best square not cleared after grid end");

endmodule

[hw/rtl/largest_empty_square_finder.sv]
`timescale 1ns / 1ps

// Largest empty square finder. Cells stream in raster order, one per beat,
// and the block takes one cell every clock cycle unless a last cell waits
// for the result register. Each cell reads the run of the cell above from a
// one-row line store (a RAM of MAX_WIDTH entries with registered read) at
// accept; in the compute stage it forms 1 + min(above, left, above-left)
// and writes the run back as it leaves; a bypass covers a one-column grid
// where the write and the next read hit the same entry. The result beat is
// registered and is loaded as the last cell leaves the compute stage, which
// that cell does only while the result register is free; further cells keep
// flowing while the result waits unless another last cell needs the result
// register. The line store needs no clearing after reset: row 0 never uses it.
// Configuration writes take effect on the next cell and belong between grids.
module largest_empty_square_finder #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [les_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [les_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [les_pkg::CHAR_W-1:0]      req_cell_char,
   input  logic                            req_end_of_grid,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_found,
   output logic [les_pkg::SIZE_W-1:0]      rsp_square_size,
   output logic [les_pkg::POS_W-1:0]       rsp_top_row,
   output logic [les_pkg::POS_W-1:0]       rsp_left_col
);

   import les_pkg::*;

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RUN_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // configuration
   logic [CSR_DATA_W-1:0] grid_width_ff, grid_width_in;
   logic [CHAR_W-1:0]     obstacle_ff, obstacle_in;
   logic [RUN_W-1:0]      width_eff;

   // position counters, advanced at accept
   logic [COL_W-1:0] col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic             req_accept;
   logic             row_end;

   // compute stage
   logic             a_valid_ff, a_valid_in;
   logic [CHAR_W-1:0] a_char_ff;
   logic             a_last_ff;
   logic             a_row_end_ff;
   logic [COL_W-1:0] a_col_ff;
   logic [ROW_W-1:0] a_row_ff;
   logic             fwd_hit_ff, fwd_hit_in;
   logic [RUN_W-1:0] fwd_data_ff;
   logic             a_advance;

   logic [RUN_W-1:0] left_run_ff, left_run_in;
   logic [RUN_W-1:0] diag_run_ff, diag_run_in;
   logic [RUN_W-1:0] ram_rdata;
   logic [RUN_W-1:0] up_run;
   logic [RUN_W-1:0] min_run;
   logic [RUN_W-1:0] cell_run;

   logic        take_ok;
   les_ctl_type best_ctl;

   // ---- configuration port
   always_comb begin
      grid_width_in = grid_width_ff;
      obstacle_in   = obstacle_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:    grid_width_in = csr_wdata;
            CSR_OBSTACLE_CHAR: obstacle_in   = csr_wdata[CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (grid_width_ff == '0) begin
         width_eff = RUN_W'(1);
      end else if (32'(grid_width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = RUN_W'(MAX_WIDTH);
      end else begin
         width_eff = RUN_W'(grid_width_ff);
      end
   end

   // ---- accept side
   assign a_advance  = a_valid_ff && (!a_last_ff || take_ok);
   assign req_stall  = a_valid_ff && !a_advance;
   assign req_accept = req_valid && !req_stall;
   assign row_end    = (RUN_W'(col_count_ff) + RUN_W'(1)) >= width_eff;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (req_accept) begin
         if (req_end_of_grid) begin
            col_count_in = '0;
            row_count_in = '0;
         end else if (row_end) begin
            col_count_in = '0;
            if (row_count_ff < ROW_W'(MAX_HEIGHT - 1)) begin
               row_count_in = row_count_ff + ROW_W'(1);
            end
         end else begin
            col_count_in = col_count_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      if (req_accept) begin
         a_valid_in = 1'b1;
      end else if (a_advance) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   // write of the retiring cell and read of the new one land on the same entry
   assign fwd_hit_in = req_accept ? (a_advance && (a_col_ff == col_count_ff)) : fwd_hit_ff;

   // ---- line store
   les_ram #(
      .WIDTH (RUN_W),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock   (clock),
      .wr_en   (a_advance),
      .wr_addr (a_col_ff),
      .wr_data (cell_run),
      .rd_en   (req_accept),
      .rd_addr (col_count_ff),
      .rd_data (ram_rdata)
   );

   // ---- run recurrence
   always_comb begin
      if (a_row_ff == '0) begin
         up_run = '0;
      end else if (fwd_hit_ff) begin
         up_run = fwd_data_ff;
      end else begin
         up_run = ram_rdata;
      end
      min_run = (up_run < left_run_ff) ? up_run : left_run_ff;
      min_run = (diag_run_ff < min_run) ? diag_run_ff : min_run;
      if (a_char_ff == obstacle_ff) begin
         cell_run = '0;
      end else if (a_row_ff == '0 || a_col_ff == '0) begin
         cell_run = RUN_W'(1);
      end else begin
         cell_run = min_run + RUN_W'(1);
      end
   end

   always_comb begin
      left_run_in = left_run_ff;
      diag_run_in = diag_run_ff;
      if (a_advance) begin
         if (a_last_ff || a_row_end_ff) begin
            left_run_in = '0;
            diag_run_in = '0;
         end else begin
            left_run_in = cell_run;
            diag_run_in = up_run;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= GRID_WIDTH_RESET;
         obstacle_ff   <= OBSTACLE_CHAR_RESET;
         col_count_ff  <= '0;
         row_count_ff  <= '0;
         a_valid_ff    <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         left_run_ff   <= '0;
         diag_run_ff   <= '0;
      end else begin
         grid_width_ff <= grid_width_in;
         obstacle_ff   <= obstacle_in;
         col_count_ff  <= col_count_in;
         row_count_ff  <= row_count_in;
         a_valid_ff    <= a_valid_in;
         fwd_hit_ff    <= fwd_hit_in;
         left_run_ff   <= left_run_in;
         diag_run_ff   <= diag_run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         a_char_ff    <= req_cell_char;
         a_last_ff    <= req_end_of_grid;
         a_row_end_ff <= row_end;
         a_col_ff     <= col_count_ff;
         a_row_ff     <= row_count_ff;
         fwd_data_ff  <= cell_run;
      end
   end

   // ---- best square and result register
   always_comb begin
      best_ctl.step = a_advance;
      best_ctl.last = a_last_ff;
   end

   les_best #(
      .RUN_W (RUN_W),
      .ROW_W (ROW_W),
      .COL_W (COL_W)
   ) u_best (
      .clock           (clock),
      .reset           (reset),
      .ctl             (best_ctl),
      .run             (cell_run),
      .row             (a_row_ff),
      .col             (a_col_ff),
      .take_ok         (take_ok),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_square_size (rsp_square_size),
      .rsp_top_row     (rsp_top_row),
      .rsp_left_col    (rsp_left_col)
   );

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (a_valid_ff && a_last_ff))
      else $error("input stalled without a held last cell");

   a_row_end_clears_col: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && (a_row_end_ff || a_last_ff)) |-> (col_count_ff == '0))
      else $error("column not cleared behind a row end");

   a_last_clears_pos: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && a_last_ff) |-> (col_count_ff == '0 && row_count_ff == '0))
      else $error("position not cleared behind a last cell");

endmodule
